/* src/replication_progress_tracker_unit_defines.svh */
// Assertion macros used by the tracker core RTL (rpt_core).
`ifndef REPLICATION_PROGRESS_TRACKER_UNIT_DEFINES_SVH
`define REPLICATION_PROGRESS_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define RPT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rpt check failed");

// next-cycle implication, disabled while reset is asserted
`define RPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rpt check failed");

`endif

/* src/rpt_pkg.sv */
// Types, codes and helpers for the replication progress tracker.
`timescale 1ns / 1ps

package rpt_pkg;

	localparam int IDX_W   = 64;
	localparam int WIN_W   = 32;
	localparam int STALL_W = 8;
	localparam int MODE_W  = 4;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 136;
	localparam int OUT_DATA_W = 168;

	// event codes
	localparam logic [MODE_W-1:0] MODE_REJECT    = 4'd0;
	localparam logic [MODE_W-1:0] MODE_ACK       = 4'd1;
	localparam logic [MODE_W-1:0] MODE_TICK      = 4'd2;
	localparam logic [MODE_W-1:0] MODE_HB_CHECK  = 4'd3;
	localparam logic [MODE_W-1:0] MODE_HB_RESET  = 4'd4;
	localparam logic [MODE_W-1:0] MODE_ADV_NEXT  = 4'd5;
	localparam logic [MODE_W-1:0] MODE_REPLICATE = 4'd6;
	localparam logic [MODE_W-1:0] MODE_PROBE     = 4'd7;
	localparam logic [MODE_W-1:0] MODE_SET_ACT   = 4'd8;
	localparam logic [MODE_W-1:0] MODE_RESET     = 4'd9;
	localparam logic [MODE_W-1:0] MODE_PAUSE     = 4'd10;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIMIT  = 8'd1;

	localparam logic [WIN_W-1:0]   WINDOW_LIMIT_RST = 32'd64;
	localparam logic [STALL_W-1:0] STALL_LIMIT_RST  = 8'd5;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [IDX_W-1:0]  log_index;
		logic [IDX_W-1:0]  reject_hint;
		logic              flag_value;
	} item_t;

	typedef struct packed {
		logic [WIN_W-1:0]   window_limit;
		logic [STALL_W-1:0] stall_tick_limit;
	} cfg_t;

	typedef struct packed {
		logic              accepted;
		logic              in_probe;
		logic [IDX_W-1:0]  next_out;
		logic [IDX_W-1:0]  matched_out;
		logic [WIN_W-1:0]  window_out;
		logic              paused_out;
		logic              active_out;
		logic              voter_out;
		logic              precondition_error;
	} result_t;

	function automatic logic [IDX_W-1:0] inc_sat(input logic [IDX_W-1:0] v);
		return (v == '1) ? v : v + 64'd1;
	endfunction

endpackage

/* src/rpt_core.sv */
// Follower progress state and the per-event update logic.
`timescale 1ns / 1ps
`include "replication_progress_tracker_unit_defines.svh"

module rpt_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  rpt_pkg::item_t   item,
	input  rpt_pkg::cfg_t    cfg,
	output rpt_pkg::result_t res
);

	logic                        probe_q, paused_q, active_q, voter_q;
	logic [rpt_pkg::IDX_W-1:0]   next_q, matched_q;
	logic [rpt_pkg::WIN_W-1:0]   win_q;
	logic [rpt_pkg::STALL_W-1:0] stall_q;

	logic                        probe_d, paused_d, active_d, voter_d;
	logic [rpt_pkg::IDX_W-1:0]   next_d, matched_d;
	logic [rpt_pkg::WIN_W-1:0]   win_d;
	logic [rpt_pkg::STALL_W-1:0] stall_d;
	logic                        acc, err;

	logic [rpt_pkg::IDX_W-1:0]   m1, n_rej, idx1;
	logic [rpt_pkg::WIN_W:0]     win_dbl;
	logic [rpt_pkg::WIN_W-1:0]   win_sat, win_lim, win_ack, win_half;
	logic                        m1_exact;

	always_comb begin
		m1       = rpt_pkg::inc_sat(matched_q);
		m1_exact = (matched_q != '1) && (next_q == m1);
		idx1     = rpt_pkg::inc_sat(item.log_index);

		// probe-state reject: clamp next between matched+1 and the rejected index
		n_rej = rpt_pkg::inc_sat(item.reject_hint);
		if (item.log_index < n_rej)
			n_rej = item.log_index;
		if (n_rej == '0)
			n_rej = 64'd1;
		if (n_rej < m1)
			n_rej = m1;

		win_dbl  = {win_q, 1'b0};
		win_sat  = win_dbl[rpt_pkg::WIN_W] ? '1 : win_dbl[rpt_pkg::WIN_W-1:0];
		win_lim  = (cfg.window_limit == '0) ? 32'd1 : cfg.window_limit;
		win_ack  = (win_sat > win_lim) ? win_lim : win_sat;
		win_half = win_q >> 1;
		if (win_half == '0)
			win_half = 32'd1;
	end

	always_comb begin
		probe_d   = probe_q;
		next_d    = next_q;
		matched_d = matched_q;
		win_d     = win_q;
		stall_d   = stall_q;
		paused_d  = paused_q;
		active_d  = active_q;
		voter_d   = voter_q;
		acc       = 1'b0;
		err       = 1'b0;
		unique case (item.mode)
			rpt_pkg::MODE_REJECT: begin
				if (!probe_q) begin
					if (item.log_index > matched_q) begin
						next_d = m1;
						win_d  = win_half;
						acc    = 1'b1;
					end
				end else if (item.log_index == next_q - 64'd1) begin
					next_d   = n_rej;
					paused_d = 1'b0;
					acc      = 1'b1;
				end
			end
			rpt_pkg::MODE_ACK: begin
				if (item.log_index > matched_q) begin
					matched_d = item.log_index;
					paused_d  = 1'b0;
					stall_d   = '0;
					win_d     = win_ack;
					acc       = 1'b1;
				end
				if (idx1 > next_q)
					next_d = idx1;
			end
			rpt_pkg::MODE_TICK: begin
				if (stall_q != '1)
					stall_d = stall_q + 8'd1;
			end
			rpt_pkg::MODE_HB_CHECK: begin
				if (m1_exact) begin
					stall_d = '0;
				end else begin
					err = (next_q <= matched_q);
					acc = (stall_q >= cfg.stall_tick_limit);
				end
			end
			rpt_pkg::MODE_HB_RESET: begin
				err = (next_q <= matched_q) || m1_exact;
				if (!probe_q) begin
					probe_d = 1'b1;
					next_d  = m1;
				end
				paused_d = 1'b0;
				stall_d  = '0;
			end
			rpt_pkg::MODE_ADV_NEXT: begin
				if (item.log_index == '0 || item.log_index <= next_q)
					err = 1'b1;
				else
					next_d = item.log_index;
			end
			rpt_pkg::MODE_REPLICATE: begin
				if (probe_q) begin
					probe_d  = 1'b0;
					next_d   = m1;
					paused_d = 1'b0;
				end else if (paused_q) begin
					err = 1'b1;
				end
			end
			rpt_pkg::MODE_PROBE: begin
				if (!probe_q) begin
					probe_d  = 1'b1;
					next_d   = m1;
					paused_d = 1'b0;
				end
			end
			rpt_pkg::MODE_SET_ACT: begin
				active_d = item.flag_value;
			end
			rpt_pkg::MODE_RESET: begin
				if (item.log_index == '0) begin
					err = 1'b1;
				end else begin
					next_d    = item.log_index;
					matched_d = '0;
					probe_d   = (item.log_index > 64'd1);
					voter_d   = item.flag_value;
					paused_d  = 1'b0;
					active_d  = 1'b1;
				end
			end
			rpt_pkg::MODE_PAUSE: begin
				paused_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q   <= 1'b1;
			next_q    <= 64'd1;
			matched_q <= '0;
			win_q     <= 32'd1;
			stall_q   <= '0;
			paused_q  <= 1'b0;
			active_q  <= 1'b1;
			voter_q   <= 1'b1;
		end else if (step) begin
			probe_q   <= probe_d;
			next_q    <= next_d;
			matched_q <= matched_d;
			win_q     <= win_d;
			stall_q   <= stall_d;
			paused_q  <= paused_d;
			active_q  <= active_d;
			voter_q   <= voter_d;
		end
	end

	assign res.accepted           = acc;
	assign res.in_probe           = probe_d;
	assign res.next_out           = next_d;
	assign res.matched_out        = matched_d;
	assign res.window_out         = win_d;
	assign res.paused_out         = paused_d;
	assign res.active_out         = active_d;
	assign res.voter_out          = voter_d;
	assign res.precondition_error = err;

	`RPT_ASSERT_IMPL(a_win_nonzero, clk, arst_n, 1'b1, win_q != '0)
	`RPT_ASSERT_NEXT(a_tick_keeps_idx, clk, arst_n, step && item.mode == rpt_pkg::MODE_TICK, $stable(next_q) && $stable(matched_q))
	`RPT_ASSERT_IMPL(a_acc_modes, clk, arst_n, step && acc, item.mode == rpt_pkg::MODE_REJECT || item.mode == rpt_pkg::MODE_ACK || item.mode == rpt_pkg::MODE_HB_CHECK)
	`RPT_ASSERT_NEXT(a_ack_clears_stall, clk, arst_n, step && item.mode == rpt_pkg::MODE_ACK && acc, stall_q == '0)
	`RPT_ASSERT_IMPL(a_adv_zero_err, clk, arst_n, step && item.mode == rpt_pkg::MODE_ADV_NEXT && item.log_index == '0, err)

endmodule

/* src/replication_progress_tracker_unit.sv */
// An accepted word goes to the input reg; its result word waits in the result reg.
// One event per cycle unless the master side stalls; the state update is combinational.
// The result register frees the input side: one event waits in the input register
// while a result is held by a stalled master side.
// Reset (arst_n low, async): pipeline empty, probe state, next 1, matched 0, window 1,
// window_limit 64, stall_tick_limit 5.
`timescale 1ns / 1ps

module replication_progress_tracker_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// log_index[63:0], reject_hint[127:64], flag_value[128], zero pad
	input  logic [rpt_pkg::IN_DATA_W-1:0]       s_tdata,
	// mode[3:0]
	input  logic [rpt_pkg::MODE_W-1:0]          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// accepted[0], in_probe[1], next_out[65:2], matched_out[129:66],
	// window_out[161:130], paused_out[162], active_out[163], voter_out[164],
	// precondition_error[165], zero pad
	output logic [rpt_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rpt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rpt_pkg::CFG_DATA_W-1:0]      cfg_data
);

	rpt_pkg::item_t   item_s1;
	logic             vld_s1;
	rpt_pkg::result_t res_s2;
	logic             vld_s2;
	rpt_pkg::result_t res_comb;
	rpt_pkg::cfg_t    cfg_q;
	logic             adv;

	assign adv       = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready  = !vld_s1 || adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.mode        <= s_tuser;
			item_s1.log_index   <= s_tdata[63:0];
			item_s1.reject_hint <= s_tdata[127:64];
			item_s1.flag_value  <= s_tdata[128];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res_comb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_limit     <= rpt_pkg::WINDOW_LIMIT_RST;
			cfg_q.stall_tick_limit <= rpt_pkg::STALL_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rpt_pkg::CFG_WINDOW_LIMIT: cfg_q.window_limit     <= cfg_data;
				rpt_pkg::CFG_STALL_LIMIT:  cfg_q.stall_tick_limit <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	rpt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_comb)
	);

	assign m_tvalid = vld_s2;
	assign m_tdata  = {2'b00,
		res_s2.precondition_error,
		res_s2.voter_out,
		res_s2.active_out,
		res_s2.paused_out,
		res_s2.window_out,
		res_s2.matched_out,
		res_s2.next_out,
		res_s2.in_probe,
		res_s2.accepted};

endmodule

/* test/replication_progress_tracker_checker.sv */
// Checker for the tracker: follows stream and config channels, predicts and compares results.
`timescale 1ns / 1ps

module replication_progress_tracker_checker import rpt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [MODE_W-1:0]     s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    outstanding,
	output logic [IDX_W-1:0]      trk_next,
	output logic [IDX_W-1:0]      trk_matched,
	output logic                  trk_probe
);

	logic [WIN_W-1:0]   lim_window;
	logic [STALL_W-1:0] lim_stall;
	logic               probe_q;
	logic [IDX_W-1:0]   next_q;
	logic [IDX_W-1:0]   matched_q;
	logic [WIN_W-1:0]   window_q;
	logic [STALL_W-1:0] stall_q;
	logic               paused_q;
	logic               active_q;
	logic               voter_q;

	result_t awaited_progress[$];

	assign trk_next    = next_q;
	assign trk_matched = matched_q;
	assign trk_probe   = probe_q;

	function automatic logic [IDX_W-1:0] bump_sat(input logic [IDX_W-1:0] v);
		return (v == {IDX_W{1'b1}}) ? v : v + 64'd1;
	endfunction

	task automatic enter_probe();
		if (!probe_q) begin
			probe_q  = 1'b1;
			next_q   = bump_sat(matched_q);
			paused_q = 1'b0;
		end
	endtask

	task automatic track_event(input item_t ev, output result_t res);
		logic [IDX_W-1:0] m1;
		logic [IDX_W-1:0] n;
		logic [WIN_W:0]   dbl;
		logic [WIN_W-1:0] cap;
		logic             acc;
		logic             err;
		acc = 1'b0;
		err = 1'b0;
		m1  = bump_sat(matched_q);
		case (ev.mode)
			MODE_REJECT: begin
				if (!probe_q) begin
					if (ev.log_index > matched_q) begin
						next_q   = m1;
						window_q = window_q >> 1;
						if (window_q == '0)
							window_q = 32'd1;
						acc = 1'b1;
					end
				end else if (ev.log_index == next_q - 64'd1) begin
					n = bump_sat(ev.reject_hint);
					if (ev.log_index < n)
						n = ev.log_index;
					if (n == '0)
						n = 64'd1;
					if (n < m1)
						n = m1;
					next_q   = n;
					paused_q = 1'b0;
					acc      = 1'b1;
				end
			end
			MODE_ACK: begin
				if (ev.log_index > matched_q) begin
					cap = (lim_window == '0) ? 32'd1 : lim_window;
					dbl = {window_q, 1'b0};
					if (dbl > {1'b0, {WIN_W{1'b1}}})
						dbl = {1'b0, {WIN_W{1'b1}}};
					if (dbl > {1'b0, cap})
						dbl = {1'b0, cap};
					matched_q = ev.log_index;
					paused_q  = 1'b0;
					stall_q   = '0;
					window_q  = dbl[WIN_W-1:0];
					acc       = 1'b1;
				end
				if (bump_sat(ev.log_index) > next_q)
					next_q = bump_sat(ev.log_index);
			end
			MODE_TICK: begin
				if (stall_q != {STALL_W{1'b1}})
					stall_q = stall_q + 8'd1;
			end
			MODE_HB_CHECK: begin
				if (matched_q != {IDX_W{1'b1}} && next_q == matched_q + 64'd1) begin
					stall_q = '0;
				end else begin
					err = (next_q <= matched_q);
					acc = (stall_q >= lim_stall);
				end
			end
			MODE_HB_RESET: begin
				err = (next_q <= matched_q) ||
					(matched_q != {IDX_W{1'b1}} && next_q == matched_q + 64'd1);
				enter_probe();
				paused_q = 1'b0;
				stall_q  = '0;
			end
			MODE_ADV_NEXT: begin
				if (ev.log_index == '0 || ev.log_index <= next_q)
					err = 1'b1;
				else
					next_q = ev.log_index;
			end
			MODE_REPLICATE: begin
				if (probe_q) begin
					probe_q  = 1'b0;
					next_q   = m1;
					paused_q = 1'b0;
				end else if (paused_q) begin
					err = 1'b1;
				end
			end
			MODE_PROBE: enter_probe();
			MODE_SET_ACT: active_q = ev.flag_value;
			MODE_RESET: begin
				if (ev.log_index == '0) begin
					err = 1'b1;
				end else begin
					next_q    = ev.log_index;
					matched_q = '0;
					probe_q   = (ev.log_index > 64'd1);
					voter_q   = ev.flag_value;
					paused_q  = 1'b0;
					active_q  = 1'b1;
				end
			end
			MODE_PAUSE: paused_q = 1'b1;
			default: ;
		endcase
		res.accepted           = acc;
		res.in_probe           = probe_q;
		res.next_out           = next_q;
		res.matched_out        = matched_q;
		res.window_out         = window_q;
		res.paused_out         = paused_q;
		res.active_out         = active_q;
		res.voter_out          = voter_q;
		res.precondition_error = err;
	endtask

	task automatic check_field(input string name, input logic [IDX_W-1:0] want,
		input logic [IDX_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t   ev;
		result_t res;
		if (!arst_n) begin
			lim_window  = WINDOW_LIMIT_RST;
			lim_stall   = STALL_LIMIT_RST;
			probe_q     = 1'b1;
			next_q      = 64'd1;
			matched_q   = '0;
			window_q    = 32'd1;
			stall_q     = '0;
			paused_q    = 1'b0;
			active_q    = 1'b1;
			voter_q     = 1'b1;
			fail_count  = 0;
			awaited_progress.delete();
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_WINDOW_LIMIT: lim_window = cfg_data;
					CFG_STALL_LIMIT:  lim_stall  = cfg_data[STALL_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (awaited_progress.size() == 0) begin
					$error("result word with nothing outstanding: %0h", m_tdata);
					fail_count++;
				end else begin
					res = awaited_progress.pop_front();
					check_field("accepted", 64'(res.accepted), 64'(m_tdata[0]));
					check_field("in_probe", 64'(res.in_probe), 64'(m_tdata[1]));
					check_field("next_out", res.next_out, m_tdata[65:2]);
					check_field("matched_out", res.matched_out, m_tdata[129:66]);
					check_field("window_out", 64'(res.window_out),
						64'(m_tdata[161:130]));
					check_field("paused_out", 64'(res.paused_out), 64'(m_tdata[162]));
					check_field("active_out", 64'(res.active_out), 64'(m_tdata[163]));
					check_field("voter_out", 64'(res.voter_out), 64'(m_tdata[164]));
					check_field("precondition_error", 64'(res.precondition_error),
						64'(m_tdata[165]));
				end
			end
			if (s_tvalid && s_tready) begin
				ev.mode        = s_tuser;
				ev.log_index   = s_tdata[63:0];
				ev.reject_hint = s_tdata[127:64];
				ev.flag_value  = s_tdata[128];
				track_event(ev, res);
				awaited_progress.push_back(res);
			end
			outstanding = awaited_progress.size();
		end
	end

endmodule

/* test/replication_progress_tracker_unit_tb.sv */
// Top of the tracker testbench: clock, reset, config writes, event stimulus and verdict.
`timescale 1ns / 1ps

module replication_progress_tracker_unit_tb;
	import rpt_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'd7;
	localparam logic [IDX_W-1:0]     IDX_MAX      = {IDX_W{1'b1}};

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [MODE_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int               fail_count;
	int               outstanding;
	logic [IDX_W-1:0] trk_next;
	logic [IDX_W-1:0] trk_matched;
	logic             trk_probe;

	int   send_idle_pct;
	int   recv_stall_pct;
	logic long_hold_req;

	replication_progress_tracker_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	replication_progress_tracker_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.trk_next    (trk_next),
		.trk_matched (trk_matched),
		.trk_probe   (trk_probe)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off so the block backs up
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		m_tready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req && !hold_done) begin
				hold_left = 300;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				m_tready  = 1'b0;
				hold_left = hold_left - 1;
			end else begin
				m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	function automatic logic [IDX_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic offer_event(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
		input logic [IDX_W-1:0] hint, input logic flag);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = mode;
		s_tdata  = {7'b0, flag, hint, idx};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// drain, let the pipeline go quiet, then load both limits
	task automatic reconfigure(input logic [CFG_DATA_W-1:0] win,
		input logic [CFG_DATA_W-1:0] stl);
		s_tvalid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		write_reg(CFG_WINDOW_LIMIT, win);
		write_reg(CFG_STALL_LIMIT, stl);
	endtask

	// mostly well-formed traffic aimed at the tracked indexes, some pure noise
	task automatic offer_random(input int count);
		int               r;
		logic [MODE_W-1:0] mode;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] hint;
		logic             flag;
		bit               noise;
		for (int i = 0; i < count; i++) begin
			r     = $urandom_range(0, 99);
			idx   = rand64();
			hint  = rand64();
			flag  = 1'($urandom_range(0, 1));
			noise = ($urandom_range(0, 9) == 0);
			if (r < 24)      mode = MODE_ACK;
			else if (r < 44) mode = MODE_REJECT;
			else if (r < 54) mode = MODE_TICK;
			else if (r < 63) mode = MODE_HB_CHECK;
			else if (r < 68) mode = MODE_HB_RESET;
			else if (r < 75) mode = MODE_ADV_NEXT;
			else if (r < 81) mode = MODE_REPLICATE;
			else if (r < 85) mode = MODE_PROBE;
			else if (r < 88) mode = MODE_SET_ACT;
			else if (r < 91) mode = MODE_RESET;
			else if (r < 98) mode = MODE_PAUSE;
			else             mode = MODE_W'($urandom_range(11, 15));
			if (!noise) begin
				case (mode)
					MODE_ACK: begin
						if ($urandom_range(0, 4) == 0)
							idx = trk_matched - 64'($urandom_range(0, 2));
						else
							idx = trk_matched + 64'($urandom_range(0, 6));
					end
					MODE_REJECT: begin
						if (trk_probe)
							idx = ($urandom_range(0, 4) != 0) ? trk_next - 64'd1
								: trk_next - 64'($urandom_range(0, 3));
						else
							idx = trk_matched + 64'($urandom_range(0, 4)) - 64'd1;
						case ($urandom_range(0, 3))
							0: hint = idx - 64'($urandom_range(0, 5));
							1: hint = trk_matched + 64'($urandom_range(0, 3));
							2: hint = IDX_MAX;
							default: ;
						endcase
					end
					MODE_ADV_NEXT: begin
						if ($urandom_range(0, 7) == 0)
							idx = '0;
						else
							idx = trk_next + 64'($urandom_range(0, 6)) - 64'd1;
					end
					MODE_RESET: begin
						if ($urandom_range(0, 3) == 0)
							idx = IDX_MAX - 64'($urandom_range(0, 3));
						else
							idx = 64'($urandom_range(0, 5));
					end
					default: ;
				endcase
			end
			offer_event(mode, idx, hint, flag);
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = '0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		long_hold_req  = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed pass at reset limits
		offer_event(MODE_ACK, 64'd0, rand64(), 1'b0);
		offer_event(MODE_ACK, 64'd3, rand64(), 1'b1);
		offer_event(MODE_REJECT, 64'd3, 64'd0, 1'b0);
		offer_event(MODE_REPLICATE, rand64(), rand64(), 1'b1);
		offer_event(MODE_REJECT, 64'd5, rand64(), 1'b0);
		offer_event(MODE_PAUSE, rand64(), rand64(), 1'b1);
		offer_event(MODE_REPLICATE, rand64(), rand64(), 1'b0); // already replicating, paused
		offer_event(MODE_HB_CHECK, rand64(), rand64(), 1'b1);
		offer_event(MODE_ADV_NEXT, 64'd0, rand64(), 1'b0);
		offer_event(MODE_ADV_NEXT, 64'd10, rand64(), 1'b0);
		offer_event(MODE_ADV_NEXT, 64'd10, rand64(), 1'b1);
		repeat (6) offer_event(MODE_TICK, rand64(), rand64(), 1'b0);
		offer_event(MODE_HB_CHECK, rand64(), rand64(), 1'b0);
		offer_event(MODE_HB_RESET, rand64(), rand64(), 1'b1);
		offer_event(MODE_HB_RESET, rand64(), rand64(), 1'b0);
		offer_event(MODE_SET_ACT, rand64(), rand64(), 1'b0);
		offer_event(MODE_RESET, 64'd0, rand64(), 1'b0);
		offer_event(MODE_RESET, 64'd1, rand64(), 1'b0);
		// indexes pinned at the top of the range
		offer_event(MODE_RESET, IDX_MAX, IDX_MAX, 1'b1);
		offer_event(MODE_ACK, IDX_MAX, '0, 1'b1);
		offer_event(MODE_HB_CHECK, rand64(), rand64(), 1'b0);
		offer_event(MODE_REJECT, IDX_MAX - 64'd1, IDX_MAX, 1'b0);
		offer_event(MODE_HB_RESET, rand64(), rand64(), 1'b1);
		offer_event(MODE_W'(12), rand64(), rand64(), 1'b1);
		offer_event(MODE_W'(15), rand64(), rand64(), 1'b0);

		// tight limits, long receiver hold-off while the sender keeps pushing
		reconfigure(32'd1, 32'd1);
		write_reg(CFG_UNMAPPED, $urandom);
		long_hold_req = 1'b1;
		offer_random(40);

		// widest limits: stall count saturation and window saturation
		reconfigure(32'hFFFF_FFFF, 32'd255);
		send_idle_pct = 61;
		offer_event(MODE_ADV_NEXT, trk_next + 64'd5, rand64(), 1'b0);
		repeat (258) offer_event(MODE_TICK, rand64(), rand64(), 1'b1);
		offer_event(MODE_HB_CHECK, rand64(), rand64(), 1'b0);
		offer_event(MODE_RESET, 64'd1, rand64(), 1'b1);
		repeat (34) offer_event(MODE_ACK, trk_matched + 64'd1, rand64(), 1'b0);
		offer_random(30);

		// zero limits, junk in the upper config bits
		reconfigure(32'd0, 32'hA5A5_5A00);
		send_idle_pct  = 0;
		recv_stall_pct = 61;
		offer_random(40);

		reconfigure(32'($urandom_range(1, 32'hFFFF_FFFF)),
			{24'($urandom_range(0, 32'hFF_FFFF)), 8'($urandom_range(1, 255))});
		send_idle_pct  = 26;
		recv_stall_pct = 26;
		offer_random(45);

		reconfigure(32'd64, 32'd5);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		offer_random(20);

		s_tvalid = 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
